@@ rtl/fpvm_pkg.sv @@
// shared constants, types and the sine table for the phase voltage modulator
// depends on nothing; every rtl file refers to it by scoped names
`default_nettype none

package fpvm_pkg;

  localparam int ANGLE_BITS  = 16;
  localparam int SINE_DEPTH  = 1024;
  localparam int SINE_IDX_W  = $clog2(SINE_DEPTH);
  localparam int SINE_W      = 16;
  localparam int VOLT_W      = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;

  localparam int SQRT_RAD_W  = 48;
  localparam int SQRT_W      = 24;
  localparam int SQRT_REM_W  = 26;
  localparam int U_W         = 33;
  localparam int DUTY_Q_W    = 17;

  localparam logic [16:0] SQRT3_Q15    = 17'd56756;
  localparam logic [31:0] INV3_RECIP   = 32'hAAAAAAAB;
  localparam logic [15:0] THIRD_Q16    = 16'd21845;
  localparam logic [15:0] TWO_THIRD_Q16 = 16'd43690;

  localparam logic [CFG_W-1:0] SUPPLY_RST = 16'd3072;
  localparam logic [CFG_W-1:0] PERIOD_RST = 16'd1000;

  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUPPLY = 1'b0,
    CFG_PERIOD = 1'b1
  } cfg_reg_t;

  typedef logic signed [SINE_W-1:0] sine_tab_t [SINE_DEPTH];

  typedef struct packed {
    logic                      valid;
    logic signed [VOLT_W-1:0]  vd;
    logic signed [VOLT_W-1:0]  vq;
    logic [ANGLE_BITS-1:0]     ang;
  } lim_item_t;

  typedef struct packed {
    logic                  valid;
    logic signed [U_W-1:0] u_a;
    logic signed [U_W-1:0] u_b;
    logic signed [U_W-1:0] u_c;
  } phase_item_t;

  // taylor series in q30, rounded to q1.15
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] v;
    logic [1:0]  quad;
    for (int k = 0; k < SINE_DEPTH; k++) begin
      t = (64'(k) << 32) / SINE_DEPTH;
      quad = t[31:30];
      r = t & (Q30_ONE - 64'd1);
      if (quad[0]) begin
        r = Q30_ONE - r;
      end
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      h  = Q30_ONE;
      h  = Q30_ONE - ((x2 * h) >> 30) / 64'd110;
      h  = Q30_ONE - ((x2 * h) >> 30) / 64'd72;
      h  = Q30_ONE - ((x2 * h) >> 30) / 64'd42;
      h  = Q30_ONE - ((x2 * h) >> 30) / 64'd20;
      h  = Q30_ONE - ((x2 * h) >> 30) / 64'd6;
      s  = (x * h) >> 30;
      v  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
      tab[k] = quad[1] ? -SINE_W'(v) : SINE_W'(v);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  function automatic logic [SINE_IDX_W-1:0] sine_idx(input logic [ANGLE_BITS-1:0] a);
    logic [ANGLE_BITS+SINE_IDX_W-1:0] p;
    p = {a, SINE_IDX_W'(0)};
    return p[ANGLE_BITS +: SINE_IDX_W];
  endfunction

endpackage

`default_nettype wire

@@ rtl/fpvm_limit.sv @@
// magnitude limiter: squares, two pipelined square roots and a pipelined scale divider
// depends on fpvm_pkg
`default_nettype none

module fpvm_limit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 en,
  input  wire                 in_valid,
  input  wire signed [15:0]   in_vq,
  input  wire signed [15:0]   in_vd,
  input  wire        [15:0]   in_ang,
  input  wire        [15:0]   supply,
  output fpvm_pkg::lim_item_t lim_out
);

  localparam int SQ_N  = fpvm_pkg::SQRT_W;
  localparam int DV_N  = fpvm_pkg::VOLT_W;
  localparam int RAD_W = fpvm_pkg::SQRT_RAD_W;
  localparam int REM_W = fpvm_pkg::SQRT_REM_W;
  localparam int RT_W  = fpvm_pkg::SQRT_W;
  localparam int VW    = fpvm_pkg::VOLT_W;

  typedef struct packed {
    logic signed [VW-1:0] vd;
    logic signed [VW-1:0] vq;
    logic [15:0]          ang;
    logic                 over;
  } meta_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [RT_W-1:0]  root;
  } sq_lane_t;

  typedef struct packed {
    logic [RT_W-1:0] rem;
    logic [VW-1:0]   lo;
  } dv_lane_t;

  function automatic sq_lane_t sq_step(input sq_lane_t x);
    sq_lane_t         y;
    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    acc   = {x.rem[REM_W-3:0], x.rad[RAD_W-1 -: 2]};
    trial = {x.root, 2'b01};
    y.rad = {x.rad[RAD_W-3:0], 2'b00};
    if (acc >= trial) begin
      y.rem  = acc - trial;
      y.root = {x.root[RT_W-2:0], 1'b1};
    end else begin
      y.rem  = acc;
      y.root = {x.root[RT_W-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic dv_lane_t dv_step(input dv_lane_t x, input logic [RT_W-1:0] den);
    dv_lane_t      y;
    logic [RT_W:0] acc;
    acc = {x.rem, x.lo[VW-1]};
    if (acc >= {1'b0, den}) begin
      y.rem = RT_W'(acc - {1'b0, den});
      y.lo  = {x.lo[VW-2:0], 1'b1};
    end else begin
      y.rem = acc[RT_W-1:0];
      y.lo  = {x.lo[VW-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic logic [VW-1:0] abs16(input logic signed [VW-1:0] v);
    return v[VW-1] ? $unsigned(VW'(-v)) : $unsigned(v);
  endfunction

  // stage 1: squares
  logic                 v1_r;
  logic signed [VW-1:0] vd1_r, vq1_r;
  logic [15:0]          ang1_r;
  logic [31:0]          dsq1_r, qsq1_r, ssq1_r;
  logic [31:0]          dsq_nxt, qsq_nxt, ssq_nxt;

  // stage 2: sum, limit test, reciprocal product for the divide by three
  logic        v2_r;
  meta_t       meta2_r;
  logic [31:0] mag2_r, ssq2_r;
  logic [63:0] prod2_r;
  logic [31:0] mag2_nxt;
  logic        over_nxt;
  logic [63:0] prod_nxt;

  // square root stages, index 0 holds the radicands
  logic [SQ_N:0] sq_v_r;
  meta_t         sq_meta_r [SQ_N+1];
  sq_lane_t      sq_u_r    [SQ_N+1];
  sq_lane_t      sq_m_r    [SQ_N+1];
  sq_lane_t      sq_u_nxt  [SQ_N+1];
  sq_lane_t      sq_m_nxt  [SQ_N+1];
  logic [30:0]   q3;
  logic [1:0]    r3;
  logic [31:0]   r3_full;
  logic [15:0]   frac3;

  // scale divider stages, index 0 holds the products
  logic [DV_N:0]   dv_v_r;
  meta_t           dv_meta_r [DV_N+1];
  logic [RT_W-1:0] dv_den_r  [DV_N+1];
  dv_lane_t        dv_d_r    [DV_N+1];
  dv_lane_t        dv_q_r    [DV_N+1];
  dv_lane_t        dv_d_nxt  [DV_N+1];
  dv_lane_t        dv_q_nxt  [DV_N+1];
  logic [39:0]     num_d, num_q;

  fpvm_pkg::lim_item_t lim_r, lim_nxt;
  logic [VW-1:0]       qd_fin, qq_fin;

  always_comb begin
    dsq_nxt  = 32'(in_vd * in_vd);
    qsq_nxt  = 32'(in_vq * in_vq);
    ssq_nxt  = 32'(supply) * 32'(supply);
    mag2_nxt = dsq1_r + qsq1_r;
    over_nxt = ({2'b00, mag2_nxt} + {1'b0, mag2_nxt, 1'b0}) > {2'b00, ssq1_r};
    prod_nxt = 64'(ssq1_r) * 64'(fpvm_pkg::INV3_RECIP);
  end

  always_comb begin
    q3      = prod2_r[63:33];
    r3_full = ssq2_r - {q3, 1'b0} - {1'b0, q3};
    r3      = r3_full[1:0];
    case (r3)
      2'd1:    frac3 = fpvm_pkg::THIRD_Q16;
      2'd2:    frac3 = fpvm_pkg::TWO_THIRD_Q16;
      default: frac3 = 16'd0;
    endcase
    sq_u_nxt[0] = '{rad: {1'b0, q3, frac3}, rem: '0, root: '0};
    sq_m_nxt[0] = '{rad: {mag2_r, 16'd0}, rem: '0, root: '0};
    for (int s = 1; s <= SQ_N; s++) begin
      sq_u_nxt[s] = sq_step(sq_u_r[s-1]);
      sq_m_nxt[s] = sq_step(sq_m_r[s-1]);
    end
  end

  always_comb begin
    num_d       = 40'(abs16(sq_meta_r[SQ_N].vd)) * 40'(sq_u_r[SQ_N].root);
    num_q       = 40'(abs16(sq_meta_r[SQ_N].vq)) * 40'(sq_u_r[SQ_N].root);
    dv_d_nxt[0] = '{rem: num_d[39:16], lo: num_d[15:0]};
    dv_q_nxt[0] = '{rem: num_q[39:16], lo: num_q[15:0]};
    for (int s = 1; s <= DV_N; s++) begin
      dv_d_nxt[s] = dv_step(dv_d_r[s-1], dv_den_r[s-1]);
      dv_q_nxt[s] = dv_step(dv_q_r[s-1], dv_den_r[s-1]);
    end
  end

  always_comb begin
    qd_fin        = dv_d_r[DV_N].lo;
    qq_fin        = dv_q_r[DV_N].lo;
    lim_nxt.valid = dv_v_r[DV_N];
    lim_nxt.ang   = dv_meta_r[DV_N].ang;
    if (dv_meta_r[DV_N].over) begin
      lim_nxt.vd = dv_meta_r[DV_N].vd[VW-1] ? $signed(VW'(-qd_fin)) : $signed(qd_fin);
      lim_nxt.vq = dv_meta_r[DV_N].vq[VW-1] ? $signed(VW'(-qq_fin)) : $signed(qq_fin);
    end else begin
      lim_nxt.vd = dv_meta_r[DV_N].vd;
      lim_nxt.vq = dv_meta_r[DV_N].vq;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      sq_v_r      <= '0;
      dv_v_r      <= '0;
      lim_r.valid <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      sq_v_r      <= {sq_v_r[SQ_N-1:0], v2_r};
      dv_v_r      <= {dv_v_r[DV_N-1:0], sq_v_r[SQ_N]};
      lim_r       <= lim_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vd1_r   <= in_vd;
      vq1_r   <= in_vq;
      ang1_r  <= in_ang;
      dsq1_r  <= dsq_nxt;
      qsq1_r  <= qsq_nxt;
      ssq1_r  <= ssq_nxt;
      meta2_r <= '{vd: vd1_r, vq: vq1_r, ang: ang1_r, over: over_nxt};
      mag2_r  <= mag2_nxt;
      ssq2_r  <= ssq1_r;
      prod2_r <= prod_nxt;
      sq_meta_r[0] <= meta2_r;
      for (int s = 0; s <= SQ_N; s++) begin
        sq_u_r[s] <= sq_u_nxt[s];
        sq_m_r[s] <= sq_m_nxt[s];
      end
      for (int s = 1; s <= SQ_N; s++) begin
        sq_meta_r[s] <= sq_meta_r[s-1];
      end
      dv_meta_r[0] <= sq_meta_r[SQ_N];
      dv_den_r[0]  <= sq_m_r[SQ_N].root;
      for (int s = 0; s <= DV_N; s++) begin
        dv_d_r[s] <= dv_d_nxt[s];
        dv_q_r[s] <= dv_q_nxt[s];
      end
      for (int s = 1; s <= DV_N; s++) begin
        dv_meta_r[s] <= dv_meta_r[s-1];
        dv_den_r[s]  <= dv_den_r[s-1];
      end
    end
  end

  assign lim_out = lim_r;

  // scaling never grows a component
  a_scale_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[DV_N] && dv_meta_r[DV_N].over |->
      (qd_fin <= abs16(dv_meta_r[DV_N].vd)) && (qq_fin <= abs16(dv_meta_r[DV_N].vq)))
    else $error("limited component exceeds command");

endmodule

`default_nettype wire

@@ rtl/fpvm_rotate.sv @@
// inverse park and inverse clarke transform, five register stages
// depends on fpvm_pkg (sine table, item types)
`default_nettype none

module fpvm_rotate (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   en,
  input  var fpvm_pkg::lim_item_t lim_in,
  output fpvm_pkg::phase_item_t ph_out
);

  localparam int AB  = fpvm_pkg::ANGLE_BITS;
  localparam int SW  = fpvm_pkg::SINE_W;
  localparam int VW  = fpvm_pkg::VOLT_W;
  localparam int UW  = fpvm_pkg::U_W;
  localparam int BMW = UW + 18;

  logic [3:0] v_r;

  logic signed [VW-1:0] vd1_r, vq1_r;
  logic signed [SW-1:0] sn1_r, cs1_r, sn_nxt, cs_nxt;
  logic [AB-1:0]        a_ang, ac_ang;

  logic signed [31:0] p_dc2_r, p_qs2_r, p_ds2_r, p_qc2_r;

  logic signed [UW-1:0] alpha3_r, beta3_r, alpha_nxt, beta_nxt;

  logic signed [UW-1:0]  alpha4_r;
  logic signed [BMW-1:0] bm4_r, bm_nxt;

  logic signed [BMW-1:0] ah, ub, uc;
  fpvm_pkg::phase_item_t ph_r, ph_nxt;

  always_comb begin
    a_ang  = lim_in.ang[15 -: AB];
    ac_ang = a_ang + fpvm_pkg::QUARTER_TURN;
    sn_nxt = fpvm_pkg::SINE_TAB[fpvm_pkg::sine_idx(a_ang)];
    cs_nxt = fpvm_pkg::SINE_TAB[fpvm_pkg::sine_idx(ac_ang)];
  end

  always_comb begin
    alpha_nxt = UW'(p_dc2_r) - UW'(p_qs2_r);
    beta_nxt  = UW'(p_ds2_r) + UW'(p_qc2_r);
    bm_nxt    = beta3_r * $signed({1'b0, fpvm_pkg::SQRT3_Q15});
  end

  always_comb begin
    ah            = BMW'(alpha4_r) <<< 15;
    ub            = bm4_r - ah;
    uc            = -bm4_r - ah;
    ph_nxt.valid  = v_r[3];
    ph_nxt.u_a    = alpha4_r;
    ph_nxt.u_b    = UW'(ub >>> 16);
    ph_nxt.u_c    = UW'(uc >>> 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      ph_r.valid  <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[2:0], lim_in.valid};
      ph_r        <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vd1_r    <= lim_in.vd;
      vq1_r    <= lim_in.vq;
      sn1_r    <= sn_nxt;
      cs1_r    <= cs_nxt;
      p_dc2_r  <= 32'(vd1_r * cs1_r);
      p_qs2_r  <= 32'(vq1_r * sn1_r);
      p_ds2_r  <= 32'(vd1_r * sn1_r);
      p_qc2_r  <= 32'(vq1_r * cs1_r);
      alpha3_r <= alpha_nxt;
      beta3_r  <= beta_nxt;
      alpha4_r <= alpha3_r;
      bm4_r    <= bm_nxt;
    end
  end

  assign ph_out = ph_r;

endmodule

`default_nettype wire

@@ rtl/fpvm_duty.sv @@
// duty conversion: scale by period, pipelined divide by supply, clamp
// depends on fpvm_pkg (item types, widths)
`default_nettype none

module fpvm_duty (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      en,
  input  var fpvm_pkg::phase_item_t ph_in,
  input  wire [15:0]               supply,
  input  wire [15:0]               period,
  output logic                     out_valid,
  output logic [15:0]              out_duty_a,
  output logic [15:0]              out_duty_b,
  output logic [15:0]              out_duty_c
);

  localparam int UW  = fpvm_pkg::U_W;
  localparam int QW  = fpvm_pkg::DUTY_Q_W;
  localparam int UPW = UW + 17;
  localparam int NW  = UPW + 1;
  localparam int NQW = NW - 15;
  localparam int N   = QW;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [15:0] rem;
    logic [QW-1:0] lo;
  } dlane_t;

  function automatic dlane_t dv_step(input dlane_t x, input logic [15:0] den);
    dlane_t      y;
    logic [16:0] acc;
    y   = x;
    acc = {x.rem, x.lo[QW-1]};
    if (acc >= {1'b0, den}) begin
      y.rem = 16'(acc - {1'b0, den});
      y.lo  = {x.lo[QW-2:0], 1'b1};
    end else begin
      y.rem = acc[15:0];
      y.lo  = {x.lo[QW-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic logic [15:0] clamp_duty(input dlane_t x, input logic [15:0] p,
                                             input logic s_zero);
    logic [15:0] r;
    if (s_zero) begin
      r = p >> 1;
    end else if (x.neg) begin
      r = 16'd0;
    end else if (x.ovf || (x.lo > {1'b0, p})) begin
      r = p;
    end else begin
      r = x.lo[15:0];
    end
    return r;
  endfunction

  logic                  v1_r, v2_r;
  logic signed [UPW-1:0] up1_r [3];
  logic [31:0]           sp1_r;
  logic signed [NW-1:0]  num [3];
  logic [NQW-1:0]        nq2_r [3];
  logic                  neg2_r [3];

  logic [N:0] dq_v_r;
  dlane_t     dq_r   [N+1][3];
  dlane_t     dq_nxt [N+1][3];

  logic        fin_valid;
  logic [15:0] res [3];
  logic        s_zero;

  logic        out_valid_r;
  logic [15:0] duty_r [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num[l] = NW'(up1_r[l]) + $signed({1'b0, sp1_r, 14'd0});
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      dq_nxt[0][l].neg = neg2_r[l];
      dq_nxt[0][l].ovf = nq2_r[l][NQW-1:QW] >= {3'b000, supply};
      dq_nxt[0][l].rem = nq2_r[l][QW+15:QW];
      dq_nxt[0][l].lo  = nq2_r[l][QW-1:0];
    end
    for (int s = 1; s <= N; s++) begin
      for (int l = 0; l < 3; l++) begin
        dq_nxt[s][l] = dv_step(dq_r[s-1][l], supply);
      end
    end
  end

  always_comb begin
    s_zero    = (supply == 16'd0);
    fin_valid = dq_v_r[N];
    for (int l = 0; l < 3; l++) begin
      res[l] = clamp_duty(dq_r[N][l], period, s_zero);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      dq_v_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= ph_in.valid;
      v2_r        <= v1_r;
      dq_v_r      <= {dq_v_r[N-1:0], v2_r};
      out_valid_r <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      up1_r[0] <= ph_in.u_a * $signed({1'b0, period});
      up1_r[1] <= ph_in.u_b * $signed({1'b0, period});
      up1_r[2] <= ph_in.u_c * $signed({1'b0, period});
      sp1_r    <= 32'(supply) * 32'(period);
      for (int l = 0; l < 3; l++) begin
        neg2_r[l] <= num[l][NW-1];
        nq2_r[l]  <= num[l][NW-1:15];
        duty_r[l] <= res[l];
      end
      for (int s = 0; s <= N; s++) begin
        for (int l = 0; l < 3; l++) begin
          dq_r[s][l] <= dq_nxt[s][l];
        end
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_duty_a = duty_r[0];
  assign out_duty_b = duty_r[1];
  assign out_duty_c = duty_r[2];

  a_duty_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid |-> (res[0] <= period) && (res[1] <= period) && (res[2] <= period))
    else $error("duty above period");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid && !s_zero |->
      (dq_r[N][0].ovf || (dq_r[N][0].rem < supply)) &&
      (dq_r[N][1].ovf || (dq_r[N][1].rem < supply)) &&
      (dq_r[N][2].ovf || (dq_r[N][2].rem < supply)))
    else $error("divider remainder not below supply");

endmodule

`default_nettype wire

@@ rtl/foc_phase_voltage_modulator_core.sv @@
// throughput: one item per cycle unless stalled; each square root, divider and product has its own stage
// a held output freezes the whole pipeline and raises in_stall in the same cycle
// reset: valid bits cleared, supply 3072 and period 1000, no clearing pass
// top level of the phase voltage modulator, holds the configuration registers
// depends on fpvm_pkg, fpvm_limit, fpvm_rotate, fpvm_duty
`default_nettype none

module foc_phase_voltage_modulator_core (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire signed [15:0]                 in_volt_q,
  input  wire signed [15:0]                 in_volt_d,
  input  wire        [15:0]                 in_elec_angle,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [15:0]                       out_duty_a,
  output logic [15:0]                       out_duty_b,
  output logic [15:0]                       out_duty_c,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire [fpvm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [fpvm_pkg::CFG_W-1:0]         cfg_data
);

  logic [15:0] supply_r, period_r;
  logic        en;

  fpvm_pkg::lim_item_t   lim;
  fpvm_pkg::phase_item_t ph;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= fpvm_pkg::SUPPLY_RST;
      period_r <= fpvm_pkg::PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (fpvm_pkg::cfg_reg_t'(cfg_index))
        fpvm_pkg::CFG_SUPPLY: supply_r <= cfg_data;
        fpvm_pkg::CFG_PERIOD: period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  fpvm_limit u_limit (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_vq    (in_volt_q),
    .in_vd    (in_volt_d),
    .in_ang   (in_elec_angle),
    .supply   (supply_r),
    .lim_out  (lim)
  );

  fpvm_rotate u_rotate (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .lim_in (lim),
    .ph_out (ph)
  );

  fpvm_duty u_duty (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .ph_in      (ph),
    .supply     (supply_r),
    .period     (period_r),
    .out_valid  (out_valid),
    .out_duty_a (out_duty_a),
    .out_duty_b (out_duty_b),
    .out_duty_c (out_duty_c)
  );

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// testbench for foc_phase_voltage_modulator_core: directed and random d/q commands and angles
// over several supply and period settings; an in-bench modulator predicts every duty triple
// depends on fpvm_pkg and foc_phase_voltage_modulator_core
`timescale 1ns / 100ps

typedef struct {
  logic [15:0] duty_a;
  logic [15:0] duty_b;
  logic [15:0] duty_c;
} duty_set_t;

class duty_scoreboard;
  duty_set_t   pending[$];
  longint      sine_lut[1024];
  longint unsigned supply;
  longint unsigned period;
  int          mismatches;
  int          faults;

  function new();
    longint unsigned t, r, x, x2, h, s, v, one, half_pi;
    longint unsigned divs[5];
    int quad;
    one = 64'd1073741824;
    half_pi = 64'd1686629713;
    divs = '{110, 72, 42, 20, 6};
    for (int k = 0; k < 1024; k++) begin
      t = (longint'(k) << 32) / 1024;
      quad = int'((t >> 30) & 3);
      r = t & (one - 1);
      if (quad[0]) begin
        r = one - r;
      end
      x = (r * half_pi) >> 30;
      x2 = (x * x) >> 30;
      h = one;
      for (int i = 0; i < 5; i++) begin
        h = one - ((x2 * h) >> 30) / divs[i];
      end
      s = (x * h) >> 30;
      v = (s * 32767 + (one >> 1)) >> 30;
      sine_lut[k] = (quad >= 2) ? -longint'(v) : longint'(v);
    end
    supply = 3072;
    period = 1000;
    mismatches = 0;
    faults = 0;
  endfunction

  function longint unsigned root_floor(longint unsigned val);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > val) b >>= 2;
    while (b != 0) begin
      if (val >= res + b) begin
        val -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function longint shrink(longint val, longint unsigned num, longint unsigned den);
    longint unsigned m;
    longint res;
    m = (val < 0) ? longint'(-val) : longint'(val);
    res = longint'((m * num) / den);
    return (val < 0) ? -res : res;
  endfunction

  function logic [15:0] phase_duty(longint u);
    longint num;
    longint unsigned d;
    if (supply == 0) begin
      return 16'(period >> 1);
    end
    num = u * longint'(period) + longint'(supply) * longint'(period) * 16384;
    if (num < 0) begin
      return 16'd0;
    end
    d = longint'(num) / (supply << 15);
    return 16'((d > period) ? period : d);
  endfunction

  function void note_command(logic signed [15:0] vq_in, logic signed [15:0] vd_in,
                             logic [15:0] ang);
    longint vq, vd, sn, cs, alpha, beta;
    longint unsigned mag2, lim2, mag_root, lim_root;
    logic [15:0] ac;
    duty_set_t e;
    vq = longint'(vq_in);
    vd = longint'(vd_in);
    mag2 = longint'(vd * vd + vq * vq);
    lim2 = supply * supply;
    if (3 * mag2 > lim2) begin
      mag_root = root_floor(mag2 << 16);
      lim_root = root_floor((lim2 << 16) / 3);
      vd = shrink(vd, lim_root, mag_root);
      vq = shrink(vq, lim_root, mag_root);
    end
    ac = ang + 16'h4000;
    sn = sine_lut[ang[15:6]];
    cs = sine_lut[ac[15:6]];
    alpha = vd * cs - vq * sn;
    beta = vd * sn + vq * cs;
    e.duty_a = phase_duty((alpha * 65536) >>> 16);
    e.duty_b = phase_duty((-alpha * 32768 + beta * 56756) >>> 16);
    e.duty_c = phase_duty((-alpha * 32768 - beta * 56756) >>> 16);
    pending.push_back(e);
  endfunction

  function void check_duties(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    duty_set_t e;
    if (pending.size() == 0) begin
      faults++;
      return;
    end
    e = pending.pop_front();
    if (a !== e.duty_a || b !== e.duty_b || c !== e.duty_c) begin
      if (mismatches < 10) begin
        $display("mismatch: expected a=%0d b=%0d c=%0d, got a=%0d b=%0d c=%0d",
                 e.duty_a, e.duty_b, e.duty_c, a, b, c);
      end
      mismatches++;
    end
  endfunction
endclass

module tb;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic signed [15:0] in_volt_q;
  logic signed [15:0] in_volt_d;
  logic [15:0] in_elec_angle;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_duty_a;
  logic [15:0] out_duty_b;
  logic [15:0] out_duty_c;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [fpvm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fpvm_pkg::CFG_W-1:0] cfg_data;

  duty_scoreboard sb;
  bit          calm;
  int          cycles;

  foc_phase_voltage_modulator_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_volt_q(in_volt_q), .in_volt_d(in_volt_d), .in_elec_angle(in_elec_angle),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_duty_a(out_duty_a), .out_duty_b(out_duty_b), .out_duty_c(out_duty_c),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
    calm = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_duties(out_duty_a, out_duty_b, out_duty_c);
    end
  end

  // result side back-pressure
  initial begin
    int n;
    out_stall = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = calm ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_command(logic [15:0] q, logic [15:0] d, logic [15:0] ang);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_volt_q <= q;
    in_volt_d <= d;
    in_elec_angle <= ang;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(q, d, ang);
  endtask

  task automatic write_reg(fpvm_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == fpvm_pkg::CFG_SUPPLY) sb.supply = 64'(val);
    else sb.period = 64'(val);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_commands(int count);
    logic [15:0] q, d, mag;
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 3);
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      case (kind)
        0: begin
          q = 16'($urandom);
          d = 16'($urandom);
        end
        1: begin
          mag = sb.supply[15:0] >> 1;
          q = 16'($urandom_range(0, mag) - (mag >> 1));
          d = 16'($urandom_range(0, mag) - (mag >> 1));
        end
        2: begin
          mag = sb.supply[15:0] >> $urandom_range(1, 3);
          q = $urandom_range(0, 1) ? mag : -mag;
          d = 16'($urandom_range(0, 255) - 128);
        end
        default: begin
          q = 16'($urandom_range(0, 2047) - 1024);
          d = 16'($urandom_range(0, 2047) - 1024);
        end
      endcase
      send_command(q, d, 16'($urandom));
    end
    calm = 0;
  endtask

  initial begin
    logic [15:0] settings[8][2];
    logic [15:0] angles[6];
    rst_n = 0;
    in_valid = 0;
    in_volt_q = 0;
    in_volt_d = 0;
    in_elec_angle = 0;
    cfg_valid = 0;
    cfg_index = fpvm_pkg::CFG_SUPPLY;
    cfg_data = 0;
    cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2AAA};
    foreach (angles[i]) send_command(16'sd0, 16'sd0, angles[i]);
    send_command(16'sh7FFF, 16'sh7FFF, 16'h1234);
    send_command(16'sh8000, 16'sh8000, 16'h9876);
    send_command(16'sh8000, 16'sh7FFF, 16'h4000);
    send_command(16'sd0, 16'sh8000, 16'h0000);
    send_command(16'sd1500, 16'sd0, 16'h0000);
    send_command(16'sd1773, 16'sd0, 16'h5555);
    send_command(16'sd1774, 16'sd0, 16'hAAAA);
    send_command(-16'sd1773, 16'sd0, 16'hC000);
    send_command(16'sd100, -16'sd100, 16'h8001);
    random_commands(200);
    drain();

    settings = '{'{16'd256, 16'd1}, '{16'd65535, 16'd65535}, '{16'd0, 16'd501},
                 '{16'd1000, 16'd0}, '{16'd256, 16'd65535}, '{16'd65535, 16'd1},
                 '{16'd12000, 16'd2000}, '{16'd3072, 16'd1000}};
    foreach (settings[p]) begin
      write_reg(fpvm_pkg::CFG_SUPPLY, settings[p][0]);
      write_reg(fpvm_pkg::CFG_PERIOD, settings[p][1]);
      send_command(16'sh7FFF, 16'sh8000, 16'h3000);
      send_command(16'sd0, 16'sd0, 16'h0000);
      random_commands(185);
      drain();
    end

    if (sb.mismatches == 0 && sb.faults == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
